### rtl/swrm_pkg.sv
// Shared types and constants of the sliding window event rate meter.
package swrm_pkg;

    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned WINDOW_W    = 20;
    localparam int unsigned THRESHOLD_W = 10;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned RATE_W      = 23;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned UNIT_W      = 32;

    // 1000 ms per second, scaled by 2^8 for the Q.8 result
    localparam int unsigned MS_PER_S        = 1000;
    localparam int unsigned Q8_PER_SECOND_MS = MS_PER_S * 256;
    localparam int unsigned Q8_SCALE_W      = 18;

    localparam int unsigned COUNT_MAX = 63;
    localparam int unsigned RATE_MAX  = 8388607;

    localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = 20'd1000;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 10'd512;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
    } t_in;

    typedef struct packed {
        logic               detected;
        logic [COUNT_W-1:0] window_count;
        logic [RATE_W-1:0]  rate_q8;
    } t_out;

    // operands and result of the shared subtract/compare unit
    typedef struct packed {
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
    } t_sub_op;

    typedef struct packed {
        logic              borrow;
        logic [UNIT_W-1:0] diff;
    } t_sub_res;

endpackage

### rtl/swrm_sub.sv
// Shared subtract/compare unit: a - b with borrow out.
module swrm_sub (
    input  swrm_pkg::t_sub_op  i_op,
    output swrm_pkg::t_sub_res o_res
);

    logic [swrm_pkg::UNIT_W:0] w_full;

    assign w_full = {1'b0, i_op.a} - {1'b0, i_op.b};

    assign o_res.borrow = w_full[swrm_pkg::UNIT_W];
    assign o_res.diff   = w_full[swrm_pkg::UNIT_W-1:0];

endmodule

### rtl/swrm_ram.sv
// Timestamp ring store: one write port, one registered read port.
module swrm_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [swrm_pkg::TIME_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [swrm_pkg::TIME_W-1:0] o_rdata
);

    logic [swrm_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [swrm_pkg::TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sliding_window_event_rate_meter_top.sv
// Top level of the sliding window event rate meter: sequencer, ring walk and divider.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------
//  in      | to block  | i_in_valid / o_in_stall     | i_in_data  (sample, now_ms)
//  out     | from block| o_out_valid / i_out_stall   | o_out_data (detected,
//          |           |                             |   window_count, rate_q8)
//  cfg     | to block  | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// A beat passes from the accepting edge through the walk, the append and the divider to the
// output register. The walk reads one timestamp a cycle from the ring port, then the
// divider retires one quotient bit a cycle of an NW = clog2(DEPTH+1) + 18 bit dividend.
// Both run through the one shared subtractor; the next beat can be taken as soon as
// the result is registered.
// Reset (synchronous, active low) empties the ring, arms the detector and restores
// the register defaults; ring contents are not cleared, the fill count covers them.
// o_in_stall is high from the accepting edge until the result is handed to the
// output register. A finished beat waits there while i_out_stall is high, and the
// next input beat is taken meanwhile.
module sliding_window_event_rate_meter_top #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  swrm_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output swrm_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [swrm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swrm_pkg::WINDOW_W-1:0]      i_cfg_data
);

    // count, ring address, dividend and step counter widths
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW  = CW + swrm_pkg::Q8_SCALE_W;
    localparam int unsigned SW  = $clog2(NW + 1);
    localparam int unsigned WW  = (NW > swrm_pkg::RATE_W) ? NW : swrm_pkg::RATE_W;
    localparam int unsigned CXW = (CW > swrm_pkg::COUNT_W) ? CW : swrm_pkg::COUNT_W;

    localparam int unsigned TW = swrm_pkg::TIME_W;
    localparam int unsigned WIN_W = swrm_pkg::WINDOW_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_APPEND = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [WIN_W-1:0]                 r_window;
    logic [swrm_pkg::THRESHOLD_W-1:0] r_threshold;

    // ring bookkeeping and detector
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_stored, n_stored;
    logic          r_disarmed, n_disarmed;

    // per-beat working registers
    logic [TW-1:0] r_now,    n_now;
    logic          r_rec,    n_rec;
    logic [CW-1:0] r_idx,    n_idx;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic          r_rd_vld, n_rd_vld;

    // divider
    logic [NW-1:0]    r_num,  n_num;
    logic [NW-1:0]    r_quot, n_quot;
    logic [WIN_W-1:0] r_rem,  n_rem;
    logic [SW-1:0]    r_step, n_step;

    // output register
    logic           r_out_valid, n_out_valid;
    swrm_pkg::t_out r_out,       n_out;

    // ring ports
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr;
    logic [TW-1:0] w_wdata, w_rdata;

    swrm_pkg::t_sub_op  w_op;
    swrm_pkg::t_sub_res w_res;

    logic [TW-1:0]    w_age;
    logic             w_in_win;
    logic [WIN_W-1:0] w_divisor;
    logic [WIN_W:0]   w_rem_sh;
    logic [CW-1:0]    w_cnt_fin;
    logic             w_accept;
    logic             w_walk_done;
    logic [WW-1:0]    w_quot_ext;
    logic [CXW-1:0]   w_cnt_ext;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + AW'(1));
    endfunction

    swrm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    swrm_sub u_sub (
        .i_op  (w_op),
        .o_res (w_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // age of the entry leaving the read register; zero window divides by one
    assign w_age       = r_now - w_rdata;
    assign w_divisor   = (r_window == '0) ? WIN_W'(1) : r_window;
    assign w_rem_sh    = {r_rem, r_num[NW-1]};
    assign w_walk_done = (r_idx == r_stored) && !r_rd_vld;

    // shared unit: window-vs-age compare during the walk, trial subtract in the divider
    always_comb begin
        if (r_state == S_DIV) begin
            w_op.a = swrm_pkg::UNIT_W'(w_rem_sh);
            w_op.b = swrm_pkg::UNIT_W'(w_divisor);
        end else begin
            w_op.a = swrm_pkg::UNIT_W'(r_window);
            w_op.b = w_age;
        end
    end

    assign w_in_win = !w_res.borrow;

    // count after this beat; a recorded beat adds now to the survivors, capped at DEPTH
    always_comb begin
        if (!r_rec) begin
            w_cnt_fin = r_cnt;
        end else if (r_cnt < CW'(DEPTH)) begin
            w_cnt_fin = CW'(r_cnt + CW'(1));
        end else begin
            w_cnt_fin = CW'(DEPTH);
        end
    end

    assign w_re = (r_state == S_WALK) && (r_idx != r_stored);

    // single write port: compaction during the walk, new timestamp at append
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr_ptr;
        w_wdata = w_rdata;
        if (r_state == S_WALK) begin
            w_we = r_rd_vld && r_rec && w_in_win;
        end else if (r_state == S_APPEND) begin
            w_we    = r_rec;
            w_wdata = r_now;
            if (r_cnt == CW'(DEPTH)) begin
                w_waddr = r_head;
            end
        end
    end

    assign w_quot_ext = WW'(r_quot);
    assign w_cnt_ext  = CXW'(r_cnt);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_stored    = r_stored;
        n_disarmed  = r_disarmed;
        n_now       = r_now;
        n_rec       = r_rec;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_rd_vld    = 1'b0;
        n_num       = r_num;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now    = i_in_data.now_ms;
                    n_rec    = 1'b0;
                    if (i_in_data.sample > r_threshold) begin
                        n_disarmed = 1'b0;
                    end else if (i_in_data.sample < r_threshold) begin
                        n_rec      = !r_disarmed;
                        n_disarmed = 1'b1;
                    end
                    n_idx    = '0;
                    n_cnt    = '0;
                    n_rd_ptr = r_head;
                    n_wr_ptr = r_head;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (w_re) begin
                    n_idx    = CW'(r_idx + CW'(1));
                    n_rd_ptr = f_inc(r_rd_ptr);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && w_in_win) begin
                    n_cnt = CW'(r_cnt + CW'(1));
                    if (r_rec) begin
                        n_wr_ptr = f_inc(r_wr_ptr);
                    end
                end
                if (w_walk_done) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (r_rec) begin
                    n_stored = w_cnt_fin;
                    if (r_cnt == CW'(DEPTH)) begin
                        n_head = f_inc(r_head);
                    end
                end
                n_cnt   = w_cnt_fin;
                n_num   = NW'(NW'(w_cnt_fin) * NW'(swrm_pkg::Q8_PER_SECOND_MS));
                n_quot  = '0;
                n_rem   = '0;
                n_step  = SW'(NW);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step != '0) begin
                    n_num  = {r_num[NW-2:0], 1'b0};
                    n_step = SW'(r_step - SW'(1));
                    if (w_res.borrow) begin
                        n_rem  = w_rem_sh[WIN_W-1:0];
                        n_quot = {r_quot[NW-2:0], 1'b0};
                    end else begin
                        n_rem  = w_res.diff[WIN_W-1:0];
                        n_quot = {r_quot[NW-2:0], 1'b1};
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.detected   = r_rec;
                    n_out.window_count = (w_cnt_ext > CXW'(swrm_pkg::COUNT_MAX)) ?
                                         swrm_pkg::COUNT_W'(swrm_pkg::COUNT_MAX) :
                                         w_cnt_ext[swrm_pkg::COUNT_W-1:0];
                    n_out.rate_q8    = (w_quot_ext > WW'(swrm_pkg::RATE_MAX)) ?
                                       swrm_pkg::RATE_W'(swrm_pkg::RATE_MAX) :
                                       w_quot_ext[swrm_pkg::RATE_W-1:0];
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_stored    <= '0;
            r_disarmed  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= swrm_pkg::WINDOW_RESET;
            r_threshold <= swrm_pkg::THRESHOLD_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_stored    <= n_stored;
            r_disarmed  <= n_disarmed;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swrm_pkg::REG_WINDOW_MS: r_window    <= i_cfg_data;
                    swrm_pkg::REG_THRESHOLD: r_threshold <=
                        i_cfg_data[swrm_pkg::THRESHOLD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_rec    <= n_rec;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_num    <= n_num;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_out    <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(DEPTH))
        else $error("fill count above ring depth");

    a_kept_le_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cnt <= r_idx))
        else $error("walk counted more entries than it read");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_divisor))
        else $error("divider remainder not below divisor");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken while a beat is in progress");

    a_detect_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.detected) |-> (o_out_data.window_count != '0))
        else $error("recorded event missing from window count");
`endif

endmodule
